>>> design/hvac_relay_sequencer_core_macros.svh
// Assertion helpers shared by the sequencer RTL.
`ifndef HVAC_RELAY_SEQUENCER_CORE_MACROS_SVH
`define HVAC_RELAY_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define HRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/hvac_rs_pkg.sv
package hvac_rs_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_TICK_W     = 16;
  localparam int CFG_TEMP_W     = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int CMD_W          = 3;
  localparam int ARG_W          = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STOP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_COOL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_HEAT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POST_COOL_FAN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_READ_TIMEOUT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT    = 3'd6;

  // Reset values
  localparam logic [CFG_TICK_W-1:0] RST_MIN_STOP      = 16'd300;
  localparam logic [CFG_TICK_W-1:0] RST_MIN_RUN_COOL  = 16'd300;
  localparam logic [CFG_TICK_W-1:0] RST_MIN_RUN_HEAT  = 16'd300;
  localparam logic [CFG_TICK_W-1:0] RST_POST_COOL_FAN = 16'd60;
  localparam logic [CFG_TICK_W-1:0] RST_READ_TIMEOUT  = 16'd600;
  localparam logic [CFG_TEMP_W-1:0] RST_LOW_LIMIT     = 8'd40;
  localparam logic [CFG_TEMP_W-1:0] RST_HIGH_LIMIT    = 8'd100;
  localparam logic [ARG_W-1:0]      RST_SETPOINT      = 8'd70;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_TEMP  = 3'd1,
    CMD_SETPT = 3'd2,
    CMD_MODE  = 3'd3,
    CMD_FAN   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_COOL = 2'd1,
    MODE_HEAT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    FLT_NONE      = 2'd0,
    FLT_INTERLOCK = 2'd1,
    FLT_TIMEOUT   = 2'd2,
    FLT_RANGE     = 2'd3
  } fault_t;

  localparam logic [ARG_W-1:0] FAN_ARG_ALWAYS = 8'd1;

  typedef struct packed {
    logic fan;
    logic cool;
    logic heat;
  } relay_t;

  typedef struct packed {
    logic [CFG_TICK_W-1:0] min_stop;
    logic [CFG_TICK_W-1:0] min_run_cool;
    logic [CFG_TICK_W-1:0] min_run_heat;
    logic [CFG_TICK_W-1:0] post_cool_fan;
    logic [CFG_TICK_W-1:0] read_timeout;
    logic [CFG_TEMP_W-1:0] low_limit;
    logic [CFG_TEMP_W-1:0] high_limit;
  } cfg_t;

  typedef struct packed {
    logic [ARG_W-1:0] setpoint;
    logic [ARG_W-1:0] temperature;
    mode_t            mode;
    logic             fan_always;
    relay_t           relays;
    fault_t           fault;
  } ctl_state_t;

endpackage

>>> design/hvac_relay_sequencer_core.sv
// An accepted input beat is held in the input register; its result is captured in the
// result register once that register is free or draining.
// Throughput: one beat per cycle unless out_ready stalls the result; the whole state update is one combinational pass.
// A result beat stalled at the output still lets one more input beat in.
// Reset (rst_n low, synchronous): registers to defaults, setpoint 70, relays off,
// counters and fault cleared, both stages empty.
`include "hvac_relay_sequencer_core_macros.svh"

module hvac_relay_sequencer_core #(
  parameter int TIMER_BITS = hvac_rs_pkg::TIMER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [hvac_rs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hvac_rs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input beats
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hvac_rs_pkg::CMD_W-1:0]       in_cmd,
  input  logic [hvac_rs_pkg::ARG_W-1:0]       in_arg_value,
  // result beats
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_heat_on,
  output logic                                out_cool_on,
  output logic                                out_fan_on,
  output logic [1:0]                          out_hvac_mode,
  output logic                                out_fan_always,
  output logic [1:0]                          out_fault_code
);
  import hvac_rs_pkg::*;

  // Input stage
  logic             in_full_r, in_full_nxt;
  logic [CMD_W-1:0] cmd_r;
  logic [ARG_W-1:0] arg_r;
  logic             in_take;
  logic             fire;

  // Controller state
  ctl_state_t            ctl_r, ctl_nxt;
  logic [TIMER_BITS-1:0] run_start_r, run_start_nxt;
  logic [TIMER_BITS-1:0] run_stop_r, run_stop_nxt;
  logic [TIMER_BITS-1:0] reading_r, reading_nxt;

  // Result stage
  logic       out_valid_r, out_valid_nxt;
  ctl_state_t res_r;

  cfg_t cfg;

  hvac_rs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Advance the held beat whenever the result register is free or draining.
  assign fire     = in_full_r && (!out_valid_r || out_ready);
  assign in_ready = !in_full_r || fire;
  assign in_take  = in_valid && in_ready;

  hvac_rs_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .cmd_i       (cmd_r),
    .arg_i       (arg_r),
    .cfg_i       (cfg),
    .ctl_i       (ctl_r),
    .run_start_i (run_start_r),
    .run_stop_i  (run_stop_r),
    .reading_i   (reading_r),
    .ctl_o       (ctl_nxt),
    .run_start_o (run_start_nxt),
    .run_stop_o  (run_stop_nxt),
    .reading_o   (reading_nxt)
  );

  always_comb begin
    in_full_nxt = in_full_r;
    if (in_take) begin
      in_full_nxt = 1'b1;
    end else if (fire) begin
      in_full_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state and the controller state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r            <= 1'b0;
      out_valid_r          <= 1'b0;
      ctl_r.setpoint       <= RST_SETPOINT;
      ctl_r.temperature    <= '0;
      ctl_r.mode           <= MODE_OFF;
      ctl_r.fan_always     <= 1'b0;
      ctl_r.relays         <= '0;
      ctl_r.fault          <= FLT_NONE;
      run_start_r          <= '0;
      run_stop_r           <= '0;
      reading_r            <= '0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        ctl_r       <= ctl_nxt;
        run_start_r <= run_start_nxt;
        run_stop_r  <= run_stop_nxt;
        reading_r   <= reading_nxt;
      end
    end
  end

  // Payload registers: capture the input beat, then the state after it
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r <= in_cmd;
      arg_r <= in_arg_value;
    end
    if (fire) begin
      res_r <= ctl_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_heat_on    = res_r.relays.heat;
  assign out_cool_on    = res_r.relays.cool;
  assign out_fan_on     = res_r.relays.fan;
  assign out_hvac_mode  = res_r.mode;
  assign out_fan_always = res_r.fan_always;
  assign out_fault_code = res_r.fault;

  // Heat and cool are never both energized.
  `HRS_ASSERT_NOW(a_no_heat_cool, clk, rst_n, 1'b1, !(ctl_r.relays.heat && ctl_r.relays.cool), "heat and cool both on")
  // Any fault keeps every relay off.
  `HRS_ASSERT_NOW(a_fault_relays_off, clk, rst_n, (ctl_r.fault != FLT_NONE), (ctl_r.relays == '0), "relay on during fault")
  // The interlock fault latches until reset.
  `HRS_ASSERT_NEXT(a_interlock_latch, clk, rst_n, (ctl_r.fault == FLT_INTERLOCK), (ctl_r.fault == FLT_INTERLOCK), "interlock fault cleared")
  // A processed beat always lands in the result register.
  `HRS_ASSERT_NEXT(a_fire_result, clk, rst_n, fire, (out_valid_r && res_r == ctl_r), "result not captured")

endmodule

>>> design/hvac_rs_cfg.sv
module hvac_rs_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [hvac_rs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hvac_rs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output hvac_rs_pkg::cfg_t                   cfg_o
);
  import hvac_rs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MIN_STOP:      cfg_nxt.min_stop      = cfg_wdata[CFG_TICK_W-1:0];
        REG_MIN_RUN_COOL:  cfg_nxt.min_run_cool  = cfg_wdata[CFG_TICK_W-1:0];
        REG_MIN_RUN_HEAT:  cfg_nxt.min_run_heat  = cfg_wdata[CFG_TICK_W-1:0];
        REG_POST_COOL_FAN: cfg_nxt.post_cool_fan = cfg_wdata[CFG_TICK_W-1:0];
        REG_READ_TIMEOUT:  cfg_nxt.read_timeout  = cfg_wdata[CFG_TICK_W-1:0];
        REG_LOW_LIMIT:     cfg_nxt.low_limit     = cfg_wdata[CFG_TEMP_W-1:0];
        REG_HIGH_LIMIT:    cfg_nxt.high_limit    = cfg_wdata[CFG_TEMP_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_stop      <= RST_MIN_STOP;
      cfg_r.min_run_cool  <= RST_MIN_RUN_COOL;
      cfg_r.min_run_heat  <= RST_MIN_RUN_HEAT;
      cfg_r.post_cool_fan <= RST_POST_COOL_FAN;
      cfg_r.read_timeout  <= RST_READ_TIMEOUT;
      cfg_r.low_limit     <= RST_LOW_LIMIT;
      cfg_r.high_limit    <= RST_HIGH_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

>>> design/hvac_rs_step.sv
module hvac_rs_step #(
  parameter int TIMER_BITS = hvac_rs_pkg::TIMER_BITS_DEF
) (
  input  logic [hvac_rs_pkg::CMD_W-1:0] cmd_i,
  input  logic [hvac_rs_pkg::ARG_W-1:0] arg_i,
  input  hvac_rs_pkg::cfg_t             cfg_i,
  input  hvac_rs_pkg::ctl_state_t       ctl_i,
  input  logic [TIMER_BITS-1:0]         run_start_i,
  input  logic [TIMER_BITS-1:0]         run_stop_i,
  input  logic [TIMER_BITS-1:0]         reading_i,
  output hvac_rs_pkg::ctl_state_t       ctl_o,
  output logic [TIMER_BITS-1:0]         run_start_o,
  output logic [TIMER_BITS-1:0]         run_stop_o,
  output logic [TIMER_BITS-1:0]         reading_o
);
  import hvac_rs_pkg::*;

  localparam int CMP_W = (TIMER_BITS > CFG_TICK_W) ? TIMER_BITS : CFG_TICK_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  function automatic logic cnt_ge(input logic [TIMER_BITS-1:0] c,
                                  input logic [CFG_TICK_W-1:0] v);
    return CMP_W'(c) >= CMP_W'(v);
  endfunction

  function automatic logic cnt_gt(input logic [TIMER_BITS-1:0] c,
                                  input logic [CFG_TICK_W-1:0] v);
    return CMP_W'(c) > CMP_W'(v);
  endfunction

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] c);
    return (c == TMAX) ? c : c + TIMER_BITS'(1);
  endfunction

  logic [CMP_W-1:0]      stop_ext;
  logic [TIMER_BITS-1:0] stop_sat;

  // Reload value for the stop timer on a mode select
  assign stop_ext = CMP_W'(cfg_i.min_stop);
  assign stop_sat = (stop_ext > CMP_W'(TMAX)) ? TMAX : TIMER_BITS'(stop_ext);

  always_comb begin
    ctl_state_t            st;
    logic [TIMER_BITS-1:0] srs;
    logic [TIMER_BITS-1:0] stp;
    logic [TIMER_BITS-1:0] rd;
    logic                  auto_fan;

    st       = ctl_i;
    srs      = run_start_i;
    stp      = run_stop_i;
    rd       = reading_i;
    auto_fan = !ctl_i.fan_always;

    case (cmd_t'(cmd_i))
      CMD_TICK: begin
        srs = sat_inc(srs);
        stp = sat_inc(stp);
        rd  = sat_inc(rd);

        if (st.fault != FLT_INTERLOCK) begin
          if (cnt_ge(rd, cfg_i.read_timeout)) begin
            st.fault = FLT_TIMEOUT;
          end else if (st.temperature < cfg_i.low_limit ||
                       st.temperature > cfg_i.high_limit) begin
            st.fault = FLT_RANGE;
          end else begin
            st.fault = FLT_NONE;
          end
        end

        if (st.fault != FLT_NONE) begin
          // drop every relay
          if (st.relays.cool || st.relays.heat) stp = '0;
          st.relays = '0;
        end else begin
          if (auto_fan && !st.relays.cool && st.mode != MODE_COOL) begin
            st.relays.fan = 1'b0;
          end else if (!auto_fan) begin
            st.relays.fan = 1'b1;
          end

          if (st.relays.cool && st.relays.heat) begin
            st.fault = FLT_INTERLOCK;
            st.mode  = MODE_OFF;
            stp      = '0;
            st.relays = '0;
          end else begin
            if (st.mode == MODE_COOL) begin
              if (st.temperature > st.setpoint) begin
                if (st.relays.cool || cnt_ge(stp, cfg_i.min_stop)) begin
                  st.relays.fan = 1'b1;
                  if (!st.relays.cool) srs = '0;
                  st.relays.cool = 1'b1;
                  if (st.relays.heat) stp = '0;
                  st.relays.heat = 1'b0;
                end
              end else if (cnt_ge(srs, cfg_i.min_run_cool)) begin
                if (st.relays.cool) stp = '0;
                st.relays.cool = 1'b0;
              end
              if (cnt_ge(stp, cfg_i.post_cool_fan) && !st.relays.cool && auto_fan) begin
                st.relays.fan = 1'b0;
              end
            end else if (st.mode == MODE_HEAT) begin
              if (st.temperature < st.setpoint) begin
                if (st.relays.heat || cnt_ge(stp, cfg_i.min_stop)) begin
                  if (!st.relays.heat) srs = '0;
                  st.relays.heat = 1'b1;
                  if (st.relays.cool) stp = '0;
                  st.relays.cool = 1'b0;
                end
              end else if (cnt_ge(srs, cfg_i.min_run_heat)) begin
                if (st.relays.heat) stp = '0;
                st.relays.heat = 1'b0;
              end
            end else if (st.relays.heat && !cnt_ge(srs, cfg_i.min_run_heat)) begin
              // hold heat through its minimum run
            end else if (st.relays.cool && !cnt_ge(srs, cfg_i.min_run_cool)) begin
              // hold cool through its minimum run
            end else begin
              if (st.relays.heat || st.relays.cool) stp = '0;
              st.relays.heat = 1'b0;
              st.relays.cool = 1'b0;
            end

            if (st.mode != MODE_HEAT && st.relays.heat &&
                cnt_gt(srs, cfg_i.min_run_heat)) begin
              stp = '0;
              st.relays.heat = 1'b0;
            end
            if (st.mode != MODE_COOL && st.relays.cool &&
                cnt_gt(srs, cfg_i.min_run_cool)) begin
              stp = '0;
              st.relays.cool = 1'b0;
            end
          end
        end
      end
      CMD_TEMP: begin
        st.temperature = arg_i;
        rd             = '0;
      end
      CMD_SETPT: begin
        st.setpoint = arg_i;
      end
      CMD_MODE: begin
        if (arg_i == ARG_W'(MODE_COOL) || arg_i == ARG_W'(MODE_HEAT)) begin
          st.mode = mode_t'(arg_i[1:0]);
          stp     = stop_sat;
        end else if (arg_i == ARG_W'(MODE_OFF)) begin
          if (st.mode == MODE_OFF) begin
            if (st.relays.heat || st.relays.cool) stp = '0;
            st.relays.heat = 1'b0;
            st.relays.cool = 1'b0;
          end
          st.mode = MODE_OFF;
        end
      end
      CMD_FAN: begin
        if (arg_i <= FAN_ARG_ALWAYS) st.fan_always = arg_i[0];
      end
      default: begin
        st = ctl_i;
      end
    endcase

    ctl_o       = st;
    run_start_o = srs;
    run_stop_o  = stp;
    reading_o   = rd;
  end

endmodule

>>> tb/hvac_rs_tb_pkg.sv
package hvac_rs_tb_pkg;
  import hvac_rs_pkg::*;

  // One result beat as seen on the out_ channel.
  typedef struct packed {
    logic   heat_on;
    logic   cool_on;
    logic   fan_on;
    mode_t  hvac_mode;
    logic   fan_always;
    fault_t fault_code;
  } relay_status_t;

  // Tracks the sequencer state beat by beat and holds the statuses still due.
  class relay_status_board;
    cfg_t                      cfg;
    logic [ARG_W-1:0]          setpoint;
    logic [ARG_W-1:0]          temperature;
    mode_t                     mode;
    logic                      fan_always;
    relay_t                    relays;
    logic [TIMER_BITS_DEF-1:0] run_age;
    logic [TIMER_BITS_DEF-1:0] stop_age;
    logic [TIMER_BITS_DEF-1:0] reading_age;
    fault_t                    fault;
    relay_status_t             status_due[$];
    int                        errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      cfg.min_stop      = RST_MIN_STOP;
      cfg.min_run_cool  = RST_MIN_RUN_COOL;
      cfg.min_run_heat  = RST_MIN_RUN_HEAT;
      cfg.post_cool_fan = RST_POST_COOL_FAN;
      cfg.read_timeout  = RST_READ_TIMEOUT;
      cfg.low_limit     = RST_LOW_LIMIT;
      cfg.high_limit    = RST_HIGH_LIMIT;
      setpoint    = RST_SETPOINT;
      temperature = '0;
      mode        = MODE_OFF;
      fan_always  = 1'b0;
      relays      = '0;
      run_age     = '0;
      stop_age    = '0;
      reading_age = '0;
      fault       = FLT_NONE;
      status_due.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MIN_STOP:      cfg.min_stop      = data;
        REG_MIN_RUN_COOL:  cfg.min_run_cool  = data;
        REG_MIN_RUN_HEAT:  cfg.min_run_heat  = data;
        REG_POST_COOL_FAN: cfg.post_cool_fan = data;
        REG_READ_TIMEOUT:  cfg.read_timeout  = data;
        REG_LOW_LIMIT:     cfg.low_limit     = data[CFG_TEMP_W-1:0];
        REG_HIGH_LIMIT:    cfg.high_limit    = data[CFG_TEMP_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return status_due.size();
    endfunction

    function logic [TIMER_BITS_DEF-1:0] bump(logic [TIMER_BITS_DEF-1:0] v);
      return (&v) ? v : v + TIMER_BITS_DEF'(1);
    endfunction

    // A start restarts the run age, a stop restarts the stop age.
    function void drive_heat(logic on);
      if (on && !relays.heat) run_age = '0;
      if (!on && relays.heat) stop_age = '0;
      relays.heat = on;
    endfunction

    function void drive_cool(logic on);
      if (on && !relays.cool) run_age = '0;
      if (!on && relays.cool) stop_age = '0;
      relays.cool = on;
    endfunction

    function void drop_all();
      relays.fan = 1'b0;
      drive_cool(1'b0);
      drive_heat(1'b0);
    endfunction

    function void run_control();
      logic auto_fan;
      auto_fan = !fan_always;
      if (auto_fan && !relays.cool && mode != MODE_COOL) relays.fan = 1'b0;
      else if (!auto_fan) relays.fan = 1'b1;
      if (relays.cool && relays.heat) begin
        fault = FLT_INTERLOCK;
        mode  = MODE_OFF;
        drop_all();
        return;
      end
      case (mode)
        MODE_COOL: begin
          if (temperature > setpoint) begin
            if (relays.cool || stop_age >= cfg.min_stop) begin
              relays.fan = 1'b1;
              drive_cool(1'b1);
              drive_heat(1'b0);
            end
          end else if (run_age >= cfg.min_run_cool) begin
            drive_cool(1'b0);
          end
          if (stop_age >= cfg.post_cool_fan && !relays.cool && auto_fan) relays.fan = 1'b0;
        end
        MODE_HEAT: begin
          if (temperature < setpoint) begin
            if (relays.heat || stop_age >= cfg.min_stop) begin
              drive_heat(1'b1);
              drive_cool(1'b0);
            end
          end else if (run_age >= cfg.min_run_heat) begin
            drive_heat(1'b0);
          end
        end
        default: begin
          // hold a running relay until its minimum run is served
          if (!((relays.heat && run_age < cfg.min_run_heat) ||
                (relays.cool && run_age < cfg.min_run_cool))) begin
            drive_heat(1'b0);
            drive_cool(1'b0);
          end
        end
      endcase
      if (mode != MODE_HEAT && relays.heat && run_age > cfg.min_run_heat) drive_heat(1'b0);
      if (mode != MODE_COOL && relays.cool && run_age > cfg.min_run_cool) drive_cool(1'b0);
    endfunction

    function void advance_tick();
      run_age     = bump(run_age);
      stop_age    = bump(stop_age);
      reading_age = bump(reading_age);
      if (fault == FLT_INTERLOCK) begin
        drop_all();
      end else if (reading_age >= cfg.read_timeout) begin
        fault = FLT_TIMEOUT;
        drop_all();
      end else if (temperature < cfg.low_limit || temperature > cfg.high_limit) begin
        fault = FLT_RANGE;
        drop_all();
      end else begin
        fault = FLT_NONE;
        run_control();
      end
    endfunction

    // Apply one accepted input beat and queue the status it must produce.
    function void note_command(logic [CMD_W-1:0] cmd, logic [ARG_W-1:0] arg);
      relay_status_t st;
      case (cmd)
        CMD_TICK: advance_tick();
        CMD_TEMP: begin
          temperature = arg;
          reading_age = '0;
        end
        CMD_SETPT: setpoint = arg;
        CMD_MODE: begin
          if (arg == ARG_W'(MODE_COOL) || arg == ARG_W'(MODE_HEAT)) begin
            mode     = mode_t'(arg[1:0]);
            stop_age = cfg.min_stop;
          end else if (arg == ARG_W'(MODE_OFF)) begin
            if (mode == MODE_OFF) begin
              drive_heat(1'b0);
              drive_cool(1'b0);
            end
            mode = MODE_OFF;
          end
        end
        CMD_FAN: if (arg <= FAN_ARG_ALWAYS) fan_always = arg[0];
        default: ;
      endcase
      st.heat_on    = relays.heat;
      st.cool_on    = relays.cool;
      st.fan_on     = relays.fan;
      st.hvac_mode  = mode;
      st.fan_always = fan_always;
      st.fault_code = fault;
      status_due.push_back(st);
    endfunction

    function void cmp_field(string name, logic [1:0] want, logic [1:0] got, time t);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", t, name, want, got);
      end
    endfunction

    function void check_status(relay_status_t got, time t);
      relay_status_t want;
      if (status_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing due, expected none actual %p", t, got);
        return;
      end
      want = status_due.pop_front();
      cmp_field("heat_on", want.heat_on, got.heat_on, t);
      cmp_field("cool_on", want.cool_on, got.cool_on, t);
      cmp_field("fan_on", want.fan_on, got.fan_on, t);
      cmp_field("hvac_mode", want.hvac_mode, got.hvac_mode, t);
      cmp_field("fan_always", want.fan_always, got.fan_always, t);
      cmp_field("fault_code", want.fault_code, got.fault_code, t);
    endfunction
  endclass

endpackage

>>> tb/hvac_relay_sequencer_core_tb.sv
module hvac_relay_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hvac_rs_pkg::*;
  import hvac_rs_tb_pkg::*;

  // Command codes the block has no meaning for, out-of-range arguments and the auto fan argument.
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;
  localparam logic [ARG_W-1:0] MODE_ARG_BAD = 8'd3;
  localparam logic [ARG_W-1:0] FAN_ARG_BAD  = 8'd2;
  localparam logic [ARG_W-1:0] FAN_ARG_AUTO = 8'd0;

  localparam int STALL_CYCLES = 200;
  localparam int TAIL_TICKS   = 20;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_cmd       = '0;
  logic [ARG_W-1:0]      in_arg_value = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic                  out_heat_on;
  logic                  out_cool_on;
  logic                  out_fan_on;
  logic [1:0]            out_hvac_mode;
  logic                  out_fan_always;
  logic [1:0]            out_fault_code;

  relay_status_board board;

  // Idle switches per side, and the request for one long receiver hold-off.
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req   = 1'b0;

  always #2 clk = ~clk;

  hvac_relay_sequencer_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_arg_value   (in_arg_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_heat_on    (out_heat_on),
    .out_cool_on    (out_cool_on),
    .out_fan_on     (out_fan_on),
    .out_hvac_mode  (out_hvac_mode),
    .out_fan_always (out_fan_always),
    .out_fault_code (out_fault_code)
  );

  // Offer one beat and hold it until the block takes it. All reads happen
  // right after the edge, so they see the values the block saw at that edge.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ARG_W-1:0] arg);
    if (tx_idle_en) begin
      while ($urandom_range(0, 99) < 19) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_arg_value <= arg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_command(cmd, arg);
  endtask

  // Stop offering, wait for every due status, then let the pipe settle.
  task automatic wait_results();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all seven registers back to back once the block is idle.
  task automatic apply_config(input cfg_t c);
    logic [CFG_IDX_W-1:0]  idx_list [7];
    logic [CFG_DATA_W-1:0] val_list [7];
    idx_list = '{REG_MIN_STOP, REG_MIN_RUN_COOL, REG_MIN_RUN_HEAT, REG_POST_COOL_FAN,
                 REG_READ_TIMEOUT, REG_LOW_LIMIT, REG_HIGH_LIMIT};
    val_list = '{c.min_stop, c.min_run_cool, c.min_run_heat, c.post_cool_fan,
                 c.read_timeout, CFG_DATA_W'(c.low_limit), CFG_DATA_W'(c.high_limit)};
    wait_results();
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_wdata <= val_list[i];
      @(posedge clk);
      board.write_reg(idx_list[i], val_list[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly ticks and plausible readings around the configured band, so the
  // relay control actually runs; the rest is setpoint, mode and fan beats, odd arguments and spare codes.
  task automatic random_beat();
    int unsigned      pick;
    int unsigned      lo;
    int unsigned      hi;
    logic [ARG_W-1:0] arg;
    pick = $urandom_range(0, 99);
    lo   = board.cfg.low_limit;
    hi   = board.cfg.high_limit;
    arg  = ARG_W'($urandom);
    if (pick < 45) begin
      send_beat(CMD_TICK, arg);
    end else if (pick < 65) begin
      if ($urandom_range(0, 99) < 85) arg = ARG_W'($urandom_range(lo, hi));
      send_beat(CMD_TEMP, arg);
    end else if (pick < 75) begin
      if ($urandom_range(0, 99) < 80) arg = ARG_W'($urandom_range(lo, hi));
      send_beat(CMD_SETPT, arg);
    end else if (pick < 85) begin
      if ($urandom_range(0, 99) < 85) arg = ARG_W'($urandom_range(0, 2));
      send_beat(CMD_MODE, arg);
    end else if (pick < 93) begin
      if ($urandom_range(0, 99) < 85) arg = ARG_W'($urandom_range(0, 1));
      send_beat(CMD_FAN, arg);
    end else if (pick < 97) begin
      send_beat(CMD_W'($urandom_range(CMD_SPARE_A, CMD_SPARE_C)), arg);
    end else begin
      send_beat(CMD_TICK, arg);
    end
  endtask

  // Receiver: check each accepted status, then pick the next ready level.
  initial begin
    relay_status_t got;
    int            hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.heat_on    = out_heat_on;
        got.cool_on    = out_cool_on;
        got.fan_on     = out_fan_on;
        got.hvac_mode  = mode_t'(out_hvac_mode);
        got.fan_always = out_fan_always;
        got.fault_code = fault_t'(out_fault_code);
        board.check_status(got, $time);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(rx_idle_en && $urandom_range(0, 99) < 19);
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("hvac_relay_sequencer_core regression: fail");
    $finish;
  end

  initial begin
    cfg_t setting;
    board = new();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on reset settings. A reading of zero after reset sits
    // below the low limit, so the range fault stands first.
    send_beat(CMD_TICK, 8'hFF);
    send_beat(CMD_TEMP, RST_LOW_LIMIT - 8'd1);
    send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_TEMP, RST_HIGH_LIMIT + 8'd1);
    send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_TEMP, RST_LOW_LIMIT);
    send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_SETPT, 8'h00);
    send_beat(CMD_SETPT, 8'hFF);
    send_beat(CMD_SETPT, RST_SETPOINT);
    // Select heat below setpoint: the stop age is preloaded, so heat starts.
    send_beat(CMD_TEMP, 8'd60);
    send_beat(CMD_MODE, ARG_W'(MODE_HEAT));
    send_beat(CMD_TICK, 8'h00);
    // Off while heating holds the minimum run; off again forces it down.
    send_beat(CMD_MODE, ARG_W'(MODE_OFF));
    send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_MODE, ARG_W'(MODE_OFF));
    // Select cool above setpoint, then switch to heat while cooling.
    send_beat(CMD_TEMP, 8'd90);
    send_beat(CMD_MODE, ARG_W'(MODE_COOL));
    send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_MODE, ARG_W'(MODE_HEAT));
    send_beat(CMD_TICK, 8'h00);
    // Out-of-range mode and fan values are dropped; spare codes do nothing.
    send_beat(CMD_MODE, MODE_ARG_BAD);
    send_beat(CMD_MODE, 8'hFF);
    send_beat(CMD_FAN, FAN_ARG_ALWAYS);
    send_beat(CMD_FAN, FAN_ARG_BAD);
    send_beat(CMD_FAN, 8'hFF);
    send_beat(CMD_FAN, FAN_ARG_AUTO);
    send_beat(CMD_SPARE_A, 8'hAA);
    send_beat(CMD_SPARE_B, 8'h55);
    send_beat(CMD_SPARE_C, 8'hFF);

    // Zero reading timeout: the timeout fault never clears.
    setting = board.cfg;
    setting.read_timeout = '0;
    apply_config(setting);
    send_beat(CMD_TEMP, 8'd70);
    send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_TICK, 8'h00);

    // Short timeout: let it expire, then recover with a fresh reading.
    setting.read_timeout = 16'd3;
    apply_config(setting);
    send_beat(CMD_TEMP, 8'd70);
    repeat (4) send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_TEMP, 8'd70);
    send_beat(CMD_TICK, 8'h00);

    // Random phases, each on its own setting.
    for (int p = 0; p < 7; p++) begin
      setting.min_stop      = 16'($urandom_range(0, 6));
      setting.min_run_cool  = 16'($urandom_range(0, 6));
      setting.min_run_heat  = 16'($urandom_range(0, 6));
      setting.post_cool_fan = 16'($urandom_range(0, 6));
      setting.read_timeout  = 16'($urandom_range(8, 40));
      setting.low_limit     = 8'($urandom_range(30, 50));
      setting.high_limit    = 8'($urandom_range(90, 110));
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      case (p)
        1: begin
          // lower extremes of every timer but the reading timeout, widest temperature band
          setting.min_stop      = '0;
          setting.min_run_cool  = '0;
          setting.min_run_heat  = '0;
          setting.post_cool_fan = '0;
          setting.low_limit     = 8'd0;
          setting.high_limit    = 8'd255;
        end
        2: begin
          // upper extremes of every timer
          setting.min_stop      = '1;
          setting.min_run_cool  = '1;
          setting.min_run_heat  = '1;
          setting.post_cool_fan = '1;
          setting.read_timeout  = '1;
          setting.low_limit     = 8'd200;
          setting.high_limit    = 8'd255;
        end
        4: begin
          // stretch with no idling on either side
          tx_idle_en = 1'b0;
          rx_idle_en = 1'b0;
        end
        5: begin
          // inverted band: every tick raises a fault, the range fault unless the reading has timed out
          setting.low_limit  = 8'd120;
          setting.high_limit = 8'd80;
        end
        6: begin
          setting.low_limit  = 8'($urandom_range(60, 80));
          setting.high_limit = setting.low_limit;
        end
        default: ;
      endcase
      apply_config(setting);
      send_beat(CMD_TEMP, ARG_W'($urandom_range(setting.low_limit, setting.high_limit)));
      send_beat(CMD_MODE, ARG_W'($urandom_range(MODE_COOL, MODE_HEAT)));
      for (int i = 0; i < 95; i++) begin
        // one long receiver stall while the sender keeps offering beats
        if (p == 3 && i == 20) hold_req = 1'b1;
        // pause the sender once per phase until every status is back
        if (i == 48) wait_results();
        random_beat();
      end
    end

    // Closing heat run on wide-open settings with no idling on either side.
    setting.min_stop      = '0;
    setting.min_run_cool  = '0;
    setting.min_run_heat  = '0;
    setting.post_cool_fan = '0;
    setting.read_timeout  = '1;
    setting.low_limit     = 8'd0;
    setting.high_limit    = 8'd255;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    apply_config(setting);
    send_beat(CMD_TEMP, 8'd50);
    send_beat(CMD_SETPT, 8'd200);
    send_beat(CMD_MODE, ARG_W'(MODE_HEAT));
    repeat (TAIL_TICKS) send_beat(CMD_TICK, ARG_W'($urandom));
    send_beat(CMD_TEMP, 8'd50);
    repeat (5) send_beat(CMD_TICK, ARG_W'($urandom));
    send_beat(CMD_MODE, ARG_W'(MODE_OFF));
    repeat (3) send_beat(CMD_TICK, ARG_W'($urandom));

    wait_results();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("hvac_relay_sequencer_core regression: pass");
    end else begin
      $display("hvac_relay_sequencer_core regression: fail");
    end
    $finish;
  end

endmodule

>>> hvac_relay_sequencer_core.f
+incdir+design
design/hvac_rs_pkg.sv
design/hvac_rs_cfg.sv
design/hvac_rs_step.sv
design/hvac_relay_sequencer_core.sv
tb/hvac_rs_tb_pkg.sv
tb/hvac_relay_sequencer_core_tb.sv
